### hdl/spq_pkg.sv
// Shared types and constants for the stable priority queue core.
// Used by spq_cell and stable_priority_queue_core; depends on nothing else.
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_SERVE  = 1'b1;

    typedef struct packed {
        logic [63:0] name;
        logic [7:0]  age;
        logic [7:0]  gender;
    } t_rec;

    typedef struct packed {
        logic ins;
        logic srv;
        t_rec rec;
    } t_ctl;

endpackage

### hdl/stable_priority_queue_core.sv
// Top level of the stable priority queue: a row of spq_cell slots and the fill count.
// Depends on spq_pkg and spq_cell.
//
// Busy never rises, so a new item (insert or serve) may be started on every clock.
// The result appears on the cycle after the item is accepted, marked by o_valid
// for one cycle, and must be taken then because the receiver cannot stall the
// block. All slots compare against the new age in parallel, and each slot loads
// from its neighbor, the new record or itself.
module stable_priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic [63:0] i_in_name,
    input  logic [7:0]  i_in_age,
    input  logic [7:0]  i_in_gender,
    output logic        o_valid,
    output logic        o_served,
    output logic        o_was_empty,
    output logic        o_was_full,
    output logic [63:0] o_out_name,
    output logic [7:0]  o_out_age,
    output logic [7:0]  o_out_gender,
    output logic [4:0]  o_occupancy
);

    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_valid;
    logic                      r_served;
    logic                      r_was_empty;
    logic                      r_was_full;
    spq_pkg::t_rec             r_out;

    logic                      is_full;
    logic                      is_empty;
    spq_pkg::t_ctl             ctl;
    logic [spq_pkg::DEPTH-1:0] occ;
    logic [spq_pkg::DEPTH-1:0] keep;
    spq_pkg::t_rec             recs [spq_pkg::DEPTH];
    spq_pkg::t_rec             zero_rec;

    assign busy     = 1'b0;
    assign zero_rec = '0;
    assign is_full  = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign is_empty = (r_count == '0);

    assign ctl.ins        = start && (i_mode == spq_pkg::MODE_INSERT) && !is_full;
    assign ctl.srv        = start && (i_mode == spq_pkg::MODE_SERVE) && !is_empty;
    assign ctl.rec.name   = i_in_name;
    assign ctl.rec.age    = i_in_age;
    assign ctl.rec.gender = i_in_gender;

    genvar g;
    generate
        for (g = 0; g < spq_pkg::DEPTH; g++) begin : g_cell
            assign occ[g] = (spq_pkg::CNT_W'(g) < r_count);
            if (g == 0) begin : g_head
                spq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_occ       (occ[g]),
                    .i_prev_keep (1'b1),
                    .i_prev      (zero_rec),
                    .i_next      (recs[g+1]),
                    .o_keep      (keep[g]),
                    .o_rec       (recs[g])
                );
            end else if (g == spq_pkg::DEPTH - 1) begin : g_tail
                spq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_occ       (occ[g]),
                    .i_prev_keep (keep[g-1]),
                    .i_prev      (recs[g-1]),
                    .i_next      (zero_rec),
                    .o_keep      (keep[g]),
                    .o_rec       (recs[g])
                );
            end else begin : g_mid
                spq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_occ       (occ[g]),
                    .i_prev_keep (keep[g-1]),
                    .i_prev      (recs[g-1]),
                    .i_next      (recs[g+1]),
                    .o_keep      (keep[g]),
                    .o_rec       (recs[g])
                );
            end
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctl.srv) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_served    <= 1'b0;
            r_was_empty <= 1'b0;
            r_was_full  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_valid     <= start;
            r_served    <= ctl.srv;
            r_was_empty <= start && (i_mode == spq_pkg::MODE_SERVE) && is_empty;
            r_was_full  <= start && (i_mode == spq_pkg::MODE_INSERT) && is_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.srv) begin
            r_out <= recs[0];
        end else begin
            r_out <= zero_rec;
        end
    end

    assign o_valid      = r_valid;
    assign o_served     = r_served;
    assign o_was_empty  = r_was_empty;
    assign o_was_full   = r_was_full;
    assign o_out_name   = r_out.name;
    assign o_out_age    = r_out.age;
    assign o_out_gender = r_out.gender;
    assign o_occupancy  = spq_pkg::OCC_W'(r_count);

endmodule

### hdl/spq_cell.sv
// One slot of the sorted queue: holds a record and trades it with its neighbors.
// Depends on spq_pkg for the record and control types.
module spq_cell (
    input  logic          i_clk,
    input  spq_pkg::t_ctl i_ctl,
    input  logic          i_occ,
    input  logic          i_prev_keep,
    input  spq_pkg::t_rec i_prev,
    input  spq_pkg::t_rec i_next,
    output logic          o_keep,
    output spq_pkg::t_rec o_rec
);

    spq_pkg::t_rec r_rec;
    spq_pkg::t_rec n_rec;

    // A stored record of equal or higher age stays put on an insert.
    assign o_keep = i_occ && (r_rec.age >= i_ctl.rec.age);
    assign o_rec  = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_ctl.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_rec = i_ctl.rec;
            end else begin
                n_rec = i_prev;
            end
        end else if (i_ctl.srv) begin
            n_rec = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule
